// ===== rtl/hwpf_pkg.sv =====
// Shared types and constants of the hop-weighted packet forwarder.
// Used by hwpf_ctrl, hwpf_dp and hop_weighted_packet_forwarder; no dependencies.

package hwpf_pkg;

   localparam int HOP_W     = 8;
   localparam int NET_W     = 2;
   localparam int FUNC_W    = 3;
   localparam int ACT_W     = 3;
   localparam int CNT_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam int NCOUNT_W  = 3;
   localparam int MASK_W    = 4;
   localparam int REQ_DAT_W = 24;
   localparam int RSP_DAT_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_SEND    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_BCAST   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RATE    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd4;

   localparam logic [ACT_W-1:0] ACT_FORWARD  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DISCARD  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_RATE_OK  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RATE_EXC = 3'd3;
   localparam logic [ACT_W-1:0] ACT_SWEEP    = 3'd4;
   localparam logic [ACT_W-1:0] ACT_BAD_NET  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_NET_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUSTED   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 3'd4;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_SINGLE,
      KIND_BCAST
   } kind_type;

   typedef struct packed {
      logic capture;
      logic load_single;
      logic load_copy;
      logic load_final;
      logic idx_inc;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     out_free;
      logic     eligible;
      logic     idx_done;
   } stat_type;

endpackage

// ===== rtl/hwpf_ctrl.sv =====
// Sequencer of the hop-weighted packet forwarder.
// Issues commands to hwpf_dp from its status; uses hwpf_pkg.

module hwpf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  hwpf_pkg::stat_type stat,
   output hwpf_pkg::cmd_type  cmd
);
   import hwpf_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_BCAST  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.kind)
               KIND_SINGLE: begin
                  if (stat.out_free) begin
                     cmd.load_single = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               KIND_BCAST: begin
                  state_in = S_BCAST;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_BCAST: begin
            priority if (stat.idx_done) begin
               if (stat.out_free) begin
                  cmd.load_final = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (stat.eligible) begin
               if (stat.out_free) begin
                  cmd.load_copy = 1'b1;
                  cmd.idx_inc   = 1'b1;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/hwpf_dp.sv =====
// Datapath of the hop-weighted packet forwarder: request register, settings,
// broadcast counters, result selection and the output register. Uses hwpf_pkg.

module hwpf_dp #(
   parameter int NUM_NETS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [hwpf_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [hwpf_pkg::CSR_DAT_W-1:0]      csr_wdata,
   input  logic [hwpf_pkg::FUNC_W-1:0]         req_tuser,
   input  logic [hwpf_pkg::REQ_DAT_W-1:0]      req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [hwpf_pkg::ACT_W-1:0]          rsp_tuser,
   output logic [hwpf_pkg::RSP_DAT_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   input  hwpf_pkg::cmd_type                   cmd,
   output hwpf_pkg::stat_type                  stat
);
   import hwpf_pkg::*;

   localparam int NET_CAP = (NUM_NETS < 4) ? NUM_NETS : 4;
   localparam logic [NCOUNT_W-1:0] NET_CAP_V = NCOUNT_W'(NET_CAP);
   localparam int CIW = (NUM_NETS > 1) ? $clog2(NUM_NETS) : 1;

   // Settings.
   logic [NCOUNT_W-1:0]  count_ff;
   logic [CSR_DAT_W-1:0] weights_ff;
   logic [MASK_W-1:0]    trusted_ff;
   logic [MASK_W-1:0]    enabled_ff;
   logic [CNT_W-1:0]     limit_ff;

   // Request being worked on.
   logic [FUNC_W-1:0] func_ff;
   logic [NET_W-1:0]  net_ff;
   logic [HOP_W-1:0]  hop_ff;
   logic [HOP_W-1:0]  lim_ff;
   logic              secure_ff;
   logic              unsafe_ff;

   logic [CNT_W-1:0] cnt_ff [NUM_NETS];
   logic [CNT_W-1:0] cnt_in [NUM_NETS];

   logic [NCOUNT_W-1:0] bidx_ff;
   logic [NCOUNT_W-1:0] bidx_in;

   logic             valid_ff, valid_in;
   logic [ACT_W-1:0] act_ff, act_in;
   logic [NET_W-1:0] onet_ff, onet_in;
   logic [HOP_W-1:0] ohop_ff, ohop_in;
   logic             ounsafe_ff, ounsafe_in;
   logic             last_ff, last_in;

   logic [NCOUNT_W-1:0] nets;
   logic                bad;
   kind_type            kind;
   logic [CIW-1:0]      cidx;
   logic [CNT_W-1:0]    cnt_rd;
   logic [CNT_W-1:0]    cnt_inc;
   logic [HOP_W-1:0]    w_net;
   logic                tr_net;
   logic [ACT_W-1:0]    s_act;
   logic [NET_W-1:0]    s_net;
   logic [HOP_W-1:0]    s_hop;
   logic                s_unsafe;
   logic [NET_W-1:0]    bi;
   logic [HOP_W-1:0]    w_bi;
   logic                tr_bi;
   logic [HOP_W-1:0]    budget;
   logic                any_load;
   logic                counts_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 3'd4;
         weights_ff <= '0;
         trusted_ff <= 4'hF;
         enabled_ff <= 4'hF;
         limit_ff   <= 16'd8;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_NET_COUNT: count_ff   <= csr_wdata[NCOUNT_W-1:0];
            CSR_WEIGHTS:   weights_ff <= csr_wdata;
            CSR_TRUSTED:   trusted_ff <= csr_wdata[MASK_W-1:0];
            CSR_ENABLED:   enabled_ff <= csr_wdata[MASK_W-1:0];
            CSR_LIMIT:     limit_ff   <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_tuser;
         net_ff    <= req_tdata[1:0];
         hop_ff    <= req_tdata[9:2];
         lim_ff    <= req_tdata[17:10];
         secure_ff <= req_tdata[18];
         unsafe_ff <= req_tdata[19];
      end
   end

   assign nets = (count_ff > NET_CAP_V) ? NET_CAP_V : count_ff;
   assign bad  = ({1'b0, net_ff} >= nets);

   always_comb begin
      priority if (func_ff > FUNC_TICK) begin
         kind = KIND_NONE;
      end else if (func_ff == FUNC_BCAST && !bad) begin
         kind = KIND_BCAST;
      end else begin
         kind = KIND_SINGLE;
      end
   end

   assign stat.kind = kind;

   assign cidx    = CIW'(net_ff);
   assign cnt_rd  = cnt_ff[cidx];
   assign cnt_inc = (cnt_rd == {CNT_W{1'b1}}) ? cnt_rd : cnt_rd + 16'd1;

   assign w_net  = weights_ff[{net_ff, 3'b000} +: HOP_W];
   assign tr_net = trusted_ff[net_ff];

   always_comb begin
      s_act    = ACT_FORWARD;
      s_net    = net_ff;
      s_hop    = '0;
      s_unsafe = 1'b0;
      priority if (func_ff == FUNC_TICK) begin
         s_act = ACT_SWEEP;
         s_net = '0;
      end else if (bad) begin
         s_act = ACT_BAD_NET;
      end else if (func_ff == FUNC_RATE) begin
         s_act = (cnt_inc >= limit_ff) ? ACT_RATE_EXC : ACT_RATE_OK;
      end else begin
         s_act    = (!tr_net && secure_ff) ? ACT_DISCARD : ACT_FORWARD;
         s_hop    = (func_ff == FUNC_SEND) ? hop_ff + w_net : hop_ff - w_net;
         s_unsafe = unsafe_ff | !tr_net;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_NETS; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (cmd.load_single && func_ff == FUNC_TICK) begin
         for (int i = 0; i < NUM_NETS; i++) begin
            cnt_in[i] = '0;
         end
      end else if (cmd.load_single && func_ff == FUNC_RATE && !bad) begin
         cnt_in[cidx] = cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_NETS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_NETS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   assign bi     = bidx_ff[NET_W-1:0];
   assign w_bi   = weights_ff[{bi, 3'b000} +: HOP_W];
   assign tr_bi  = trusted_ff[bi];
   assign budget = (hop_ff <= lim_ff) ? lim_ff - hop_ff : '0;

   assign stat.eligible = enabled_ff[bi] && (!secure_ff || tr_bi) &&
                          (w_bi <= budget) && (bi != net_ff);
   assign stat.idx_done = (bidx_ff >= nets);
   assign stat.out_free = !valid_ff || rsp_tready;

   always_comb begin
      bidx_in = bidx_ff;
      if (cmd.capture) begin
         bidx_in = '0;
      end else if (cmd.idx_inc) begin
         bidx_in = bidx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bidx_ff <= '0;
      end else begin
         bidx_ff <= bidx_in;
      end
   end

   assign any_load = cmd.load_single || cmd.load_copy || cmd.load_final;

   always_comb begin
      act_in     = act_ff;
      onet_in    = onet_ff;
      ohop_in    = ohop_ff;
      ounsafe_in = ounsafe_ff;
      last_in    = last_ff;
      priority if (cmd.load_single) begin
         act_in     = s_act;
         onet_in    = s_net;
         ohop_in    = s_hop;
         ounsafe_in = s_unsafe;
         last_in    = 1'b1;
      end else if (cmd.load_copy) begin
         act_in     = ACT_FORWARD;
         onet_in    = bi;
         ohop_in    = hop_ff + w_bi;
         ounsafe_in = unsafe_ff | !tr_bi;
         last_in    = 1'b0;
      end else if (cmd.load_final) begin
         act_in     = ACT_DISCARD;
         onet_in    = net_ff;
         ohop_in    = hop_ff;
         ounsafe_in = unsafe_ff;
         last_in    = 1'b1;
      end else begin
      end
      valid_in = any_load || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      act_ff     <= act_in;
      onet_ff    <= onet_in;
      ohop_ff    <= ohop_in;
      ounsafe_ff <= ounsafe_in;
      last_ff    <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = act_ff;
   assign rsp_tdata  = {5'b00000, ounsafe_ff, ohop_ff, onet_ff};
   assign rsp_tlast  = last_ff;

   always_comb begin
      counts_zero = 1'b1;
      for (int i = 0; i < NUM_NETS; i++) begin
         if (cnt_ff[i] != '0) begin
            counts_zero = 1'b0;
         end
      end
   end

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_single, cmd.load_copy, cmd.load_final}))
      else $error("More than one result loaded in a cycle.");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      any_load |-> stat.out_free)
      else $error("Result loaded over an unaccepted result.");

   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_single && func_ff == FUNC_TICK) |=> counts_zero)
      else $error("Sweep tick left a broadcast count set.");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      bidx_ff <= 3'd4)
      else $error("Broadcast index ran past the last network.");

endmodule

// ===== rtl/hop_weighted_packet_forwarder.sv =====
// Hop-weighted packet forwarder, top level.
// Requests enter on req_* (func in req_tuser), results leave on rsp_* (action in
// rsp_tuser), settings are written on csr_*. An accepted request is decoded in
// the next cycle. Send, reverse, rate check, sweep tick and a bad network give
// one result, loaded into the output register from the decode state when free.
// A broadcast walks the live networks one per cycle, loading a copy for each
// eligible one and pausing while the output register is not free, then loads a
// closing discard with rsp_tlast high. Func codes 5 to 7 give no result.
// The sequencer handles one request at a time and takes no new one until
// it is through with the last one, including the whole broadcast walk.
// The output register frees the request side: a new request is taken while a
// finished result still waits. When the receiver stalls, the walk pauses on the
// next result until rsp_tready frees the output register.
// Synchronous reset restores the settings to 4 networks, zero weights, all
// networks trusted and enabled and a broadcast limit of 8, clears the
// broadcast counters and drops any pending result.

module hop_weighted_packet_forwarder #(
   parameter int NUM_NETS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [hwpf_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [hwpf_pkg::CSR_DAT_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // func
   input  logic [hwpf_pkg::FUNC_W-1:0]        req_tuser,
   // network, hop_count, hop_limit, secure_flag, unsafe_in, zero fill
   input  logic [hwpf_pkg::REQ_DAT_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // action
   output logic [hwpf_pkg::ACT_W-1:0]         rsp_tuser,
   // out_network, out_hop_count, out_unsafe, zero fill
   output logic [hwpf_pkg::RSP_DAT_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);
   import hwpf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   hwpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hwpf_dp #(
      .NUM_NETS (NUM_NETS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for hop_weighted_packet_forwarder: directed requests from a table,
// then random phases under several settings, checked against a built-in predictor.
// Depends on hwpf_pkg and the forwarder RTL only.

module tb;
   import hwpf_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;
   localparam int PLAN_SPLIT = 9;
   localparam int PLAN_ROWS  = 20;
   localparam int PHASES     = 6;
   localparam int PHASE_REQS = 30;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [NET_W-1:0]  net;
      logic [HOP_W-1:0]  hops;
      logic [HOP_W-1:0]  limit;
      logic              secure;
      logic              unsafe;
   } hdr_op_type;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic [NET_W-1:0] net;
      logic [HOP_W-1:0] hops;
      logic             unsafe;
      logic             last;
   } outcome_type;

   typedef struct packed {
      hdr_op_type  op;
      logic        typed;
      logic        yields;
      outcome_type want;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [FUNC_W-1:0]    req_tuser = '0;
   logic [REQ_DAT_W-1:0] req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [ACT_W-1:0]     rsp_tuser;
   logic [RSP_DAT_W-1:0] rsp_tdata;
   logic                 rsp_tlast;

   logic [NCOUNT_W-1:0]  live_count = 3'd4;
   logic [31:0]          hop_weights = 32'd0;
   logic [MASK_W-1:0]    trust_bits = 4'hF;
   logic [MASK_W-1:0]    bcast_enable = 4'hF;
   logic [CNT_W-1:0]     bcast_limit = 16'd8;
   logic [CNT_W-1:0]     bcast_tally [4] = '{default: '0};

   outcome_type pending_outcomes[$];
   int          mismatch_count = 0;

   plan_row_type plan [PLAN_ROWS] = '{
      '{'{FUNC_TICK, 2'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1, 1'b1,
        '{ACT_SWEEP, 2'd0, 8'd0, 1'b0, 1'b1}},
      '{'{FUNC_RATE, 2'd3, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1, 1'b1,
        '{ACT_RATE_OK, 2'd3, 8'd0, 1'b0, 1'b1}},
      '{'{FUNC_SEND, 2'd0, 8'd255, 8'd0, 1'b1, 1'b1}, 1'b1, 1'b1,
        '{ACT_FORWARD, 2'd0, 8'd255, 1'b1, 1'b1}},
      '{'{FUNC_REVERSE, 2'd3, 8'd0, 8'd255, 1'b0, 1'b0}, 1'b1, 1'b1,
        '{ACT_FORWARD, 2'd3, 8'd0, 1'b0, 1'b1}},
      '{'{FUNC_SPARE_A, 2'd1, 8'd5, 8'd9, 1'b0, 1'b1}, 1'b1, 1'b0, '0},
      '{'{FUNC_SPARE_B, 2'd2, 8'd0, 8'd255, 1'b1, 1'b0}, 1'b1, 1'b0, '0},
      '{'{FUNC_SPARE_C, 2'd3, 8'd255, 8'd255, 1'b1, 1'b1}, 1'b1, 1'b0, '0},
      '{'{FUNC_BCAST, 2'd1, 8'd0, 8'd255, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
      '{'{FUNC_BCAST, 2'd2, 8'd200, 8'd100, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
      '{'{FUNC_SEND, 2'd3, 8'd17, 8'd40, 1'b0, 1'b0}, 1'b1, 1'b1,
        '{ACT_BAD_NET, 2'd3, 8'd0, 1'b0, 1'b1}},
      '{'{FUNC_RATE, 2'd3, 8'd0, 8'd0, 1'b0, 1'b1}, 1'b1, 1'b1,
        '{ACT_BAD_NET, 2'd3, 8'd0, 1'b0, 1'b1}},
      '{'{FUNC_BCAST, 2'd3, 8'd0, 8'd255, 1'b1, 1'b1}, 1'b1, 1'b1,
        '{ACT_BAD_NET, 2'd3, 8'd0, 1'b0, 1'b1}},
      '{'{FUNC_SEND, 2'd0, 8'd255, 8'd255, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
      '{'{FUNC_REVERSE, 2'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{FUNC_SEND, 2'd2, 8'd10, 8'd20, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{FUNC_RATE, 2'd1, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{FUNC_BCAST, 2'd1, 8'd250, 8'd255, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{FUNC_BCAST, 2'd0, 8'd3, 8'd1, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
      '{'{FUNC_TICK, 2'd2, 8'd255, 8'd0, 1'b1, 1'b1}, 1'b1, 1'b1,
        '{ACT_SWEEP, 2'd0, 8'd0, 1'b0, 1'b1}},
      '{'{FUNC_RATE, 2'd1, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b0, 1'b0, '0}
   };

   hop_weighted_packet_forwarder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Works out the results of one request and updates the broadcast tallies.
   function automatic void forecast_outcomes(input hdr_op_type op, ref outcome_type res[$]);
      int               live;
      logic [HOP_W-1:0] budget;
      logic [HOP_W-1:0] w;
      logic             tr;
      res.delete();
      live = (live_count > 3'd4) ? 4 : int'(live_count);
      if (op.func > FUNC_TICK) return;
      if (op.func == FUNC_TICK) begin
         foreach (bcast_tally[i]) bcast_tally[i] = '0;
         res.push_back('{ACT_SWEEP, 2'd0, 8'd0, 1'b0, 1'b1});
         return;
      end
      if (int'(op.net) >= live) begin
         res.push_back('{ACT_BAD_NET, op.net, 8'd0, 1'b0, 1'b1});
         return;
      end
      unique case (op.func)
         FUNC_SEND, FUNC_REVERSE: begin
            w  = hop_weights[8*op.net +: 8];
            tr = trust_bits[op.net];
            res.push_back('{(!tr && op.secure) ? ACT_DISCARD : ACT_FORWARD, op.net,
                            (op.func == FUNC_SEND) ? op.hops + w : op.hops - w,
                            op.unsafe | !tr, 1'b1});
         end
         FUNC_RATE: begin
            if (bcast_tally[op.net] != 16'hFFFF)
               bcast_tally[op.net] = bcast_tally[op.net] + 16'd1;
            res.push_back('{(bcast_tally[op.net] >= bcast_limit) ? ACT_RATE_EXC : ACT_RATE_OK,
                            op.net, 8'd0, 1'b0, 1'b1});
         end
         default: begin
            budget = (op.hops <= op.limit) ? op.limit - op.hops : 8'd0;
            for (int i = 0; i < live; i++) begin
               w  = hop_weights[8*i +: 8];
               tr = trust_bits[i];
               if (bcast_enable[i] && !(op.secure && !tr) && w <= budget && i != op.net)
                  res.push_back('{ACT_FORWARD, 2'(i), op.hops + w, op.unsafe | !tr, 1'b0});
            end
            res.push_back('{ACT_DISCARD, op.net, op.hops, op.unsafe, 1'b1});
         end
      endcase
   endfunction

   // Presents one request and returns at the edge where it is accepted.
   task automatic issue(input hdr_op_type op, input logic typed, input logic yields,
                        input outcome_type want);
      int          gap;
      outcome_type predicted[$];
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op.func;
      req_tdata  <= {4'b0, op.unsafe, op.secure, op.limit, op.hops, op.net};
      do @(posedge clock); while (!req_tready);
      forecast_outcomes(op, predicted);
      if (typed) begin
         if (yields) pending_outcomes.push_back(want);
      end else begin
         foreach (predicted[i]) pending_outcomes.push_back(predicted[i]);
      end
   endtask

   task automatic settle(input int tail);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_settings(input logic [NCOUNT_W-1:0] nc, input logic [31:0] w,
                                 input logic [MASK_W-1:0] tm, input logic [MASK_W-1:0] em,
                                 input logic [CNT_W-1:0] lim);
      live_count   = nc;
      hop_weights  = w;
      trust_bits   = tm;
      bcast_enable = em;
      bcast_limit  = lim;
      csr_we <= 1'b1;
      csr_addr <= CSR_NET_COUNT;
      csr_wdata <= 32'(nc);
      @(posedge clock);
      csr_addr <= CSR_WEIGHTS;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr <= CSR_TRUSTED;
      csr_wdata <= 32'(tm);
      @(posedge clock);
      csr_addr <= CSR_ENABLED;
      csr_wdata <= 32'(em);
      @(posedge clock);
      csr_addr <= CSR_LIMIT;
      csr_wdata <= 32'(lim);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic void check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result: action %0d, network %0d", rsp_tuser, rsp_tdata[1:0]);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("action", want.act, rsp_tuser);
            check_field("out_network", want.net, rsp_tdata[1:0]);
            check_field("out_hop_count", want.hops, rsp_tdata[9:2]);
            check_field("out_unsafe", want.unsafe, rsp_tdata[10]);
            check_field("last", want.last, rsp_tlast);
         end
      end
   end

   initial begin : rsp_side
      int n;
      forever begin
         @(posedge clock);
         rsp_tready <= 1'b1;
         n = ($urandom_range(0, 99) < 10) ? 60 : $urandom_range(1, 12);
         repeat (n) @(posedge clock);
         n = idle_len();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      hdr_op_type          op;
      int                  done;
      int                  r;
      logic [31:0]         w;
      logic [NCOUNT_W-1:0] nc;
      logic [CNT_W-1:0]    lim;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < PLAN_SPLIT; k++)
         issue(plan[k].op, plan[k].typed, plan[k].yields, plan[k].want);
      settle(10);
      write_settings(3'd3, 32'h00FF_0501, 4'b1010, 4'b1101, 16'd1);
      for (int k = PLAN_SPLIT; k < PLAN_ROWS; k++)
         issue(plan[k].op, plan[k].typed, plan[k].yields, plan[k].want);
      for (int p = 0; p < PHASES; p++) begin
         settle(10);
         for (int b = 0; b < 4; b++) begin
            r = $urandom_range(0, 99);
            w[8*b +: 8] = (r < 60) ? 8'($urandom_range(0, 15)) :
                          (r < 85) ? 8'($urandom_range(0, 80)) : 8'($urandom);
         end
         if (p == 4) w = 32'hFFFF_FFFF;
         if (p == 5) w = 32'h0;
         nc  = (p == 0) ? 3'd1 : (p == PHASES - 1) ? 3'd4 : 3'($urandom_range(1, 4));
         lim = (p == 1) ? 16'd1 : (p == 2) ? 16'hFFFF : 16'($urandom_range(1, 12));
         write_settings(nc, w, 4'($urandom), (p == 5) ? 4'hF : 4'($urandom), lim);
         done = 0;
         while (done < PHASE_REQS) begin
            r = $urandom_range(0, 99);
            op.func = (r < 12) ? FUNC_SEND : (r < 24) ? FUNC_REVERSE :
                      (r < 60) ? FUNC_BCAST : (r < 82) ? FUNC_RATE :
                      (r < 92) ? FUNC_TICK : FUNC_W'($urandom_range(5, 7));
            op.net  = NET_W'($urandom_range(0, 3));
            op.hops = HOP_W'($urandom);
            op.limit = ($urandom_range(0, 99) < 70) ?
                       HOP_W'($urandom_range(op.hops, 255)) : HOP_W'($urandom);
            op.secure = ($urandom_range(0, 99) < 30);
            op.unsafe = 1'($urandom);
            issue(op, 1'b0, 1'b0, '0);
            if (op.func <= FUNC_TICK) done++;
         end
      end
      settle(20);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #10000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
